@@ sv/sps_pkg.sv @@
// Shared types and constants for the proximity sensitivity supervisor.
// No dependencies.
package sps_pkg;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_WOOD   = 2'd1,
    ACT_RECAL  = 2'd2,
    ACT_NORMAL = 2'd3
  } sps_action_t;

  localparam logic [1:0] CFG_IDX_ENABLE = 2'd0;
  localparam logic [1:0] CFG_IDX_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_IDX_MODEM  = 2'd2;

  localparam logic [7:0] RECAL_LIMIT_RST = 8'h0A;

  localparam logic [7:0] ST_CH2     = 8'h02;
  localparam logic [7:0] ST_CH6     = 8'h20;
  localparam logic [7:0] ST_BOTH    = 8'h22;
  localparam logic [7:0] DELTA_OVF  = 8'h7F;
  localparam logic [7:0] MID_LO     = 8'h0A;
  localparam logic [7:0] MID_HI     = 8'h3F;
  localparam logic [7:0] WIN_LO     = 8'h60;
  localparam logic [7:0] RAIL_LO    = 8'h00;
  localparam logic [7:0] RAIL_HI    = 8'hFF;

  typedef struct packed {
    logic       sensor_enabled;
    logic [7:0] recal_limit;
    logic       modem_line_enable;
  } sps_cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] status;
    logic [7:0] delta_ch2;
    logic [7:0] delta_ch6;
  } sps_item_t;

  typedef struct packed {
    logic        object_detected;
    logic        detect_updated;
    logic        modem_line_write;
    sps_action_t action;
    logic        resample_request;
  } sps_result_t;

endpackage

@@ sv/sps_cfg_regs.sv @@
// Configuration register file: enable, recalibration limit, modem line enable.
// Depends on sps_pkg.
module sps_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [7:0]        wr_data,
  output sps_pkg::sps_cfg_t cfg
);
  import sps_pkg::*;

  sps_cfg_t cfg_r;
  sps_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_IDX_ENABLE: cfg_nxt.sensor_enabled    = wr_data[0];
        CFG_IDX_LIMIT:  cfg_nxt.recal_limit       = wr_data;
        CFG_IDX_MODEM:  cfg_nxt.modem_line_enable = wr_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_enabled    <= 1'b0;
      cfg_r.recal_limit       <= RECAL_LIMIT_RST;
      cfg_r.modem_line_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/sps_policy.sv @@
// Sensitivity policy: mode, counters, overflow snapshot and detect flag,
// with the single-pass next-state and result logic. Depends on sps_pkg.
module sps_policy (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  sps_pkg::sps_item_t   item,
  input  sps_pkg::sps_cfg_t    cfg,
  output sps_pkg::sps_result_t result
);
  import sps_pkg::*;

  logic       wood_r,   wood_nxt;
  logic [7:0] snap_r,   snap_nxt;
  logic [7:0] cnt2_r,   cnt2_nxt;
  logic [7:0] cnt6_r,   cnt6_nxt;
  logic       detect_r, detect_nxt;

  logic ovf;
  logic rel;
  logic in_win2, in_win6;
  logic rail2, rail6;
  logic mid2, mid6;

  always_comb begin
    in_win2 = item.delta_ch2 inside {[WIN_LO:DELTA_OVF]};
    in_win6 = item.delta_ch6 inside {[WIN_LO:DELTA_OVF]};
    rail2   = item.delta_ch2 inside {RAIL_LO, RAIL_HI};
    rail6   = item.delta_ch6 inside {RAIL_LO, RAIL_HI};
    mid2    = item.delta_ch2 inside {[MID_LO:MID_HI]};
    mid6    = item.delta_ch6 inside {[MID_LO:MID_HI]};

    ovf = ((item.status == ST_CH2) && (item.delta_ch2 == DELTA_OVF)) ||
          ((item.status == ST_CH6) && (item.delta_ch6 == DELTA_OVF)) ||
          ((item.status == ST_BOTH) &&
           ((item.delta_ch2 == DELTA_OVF) || (item.delta_ch6 == DELTA_OVF)));

    rel = (rail2 && rail6) ||
          ((snap_r == ST_CH2) && in_win2) ||
          ((snap_r == ST_CH6) && in_win6) ||
          ((snap_r == ST_BOTH) && (in_win2 || in_win6));

    wood_nxt   = wood_r;
    snap_nxt   = snap_r;
    cnt2_nxt   = cnt2_r;
    cnt6_nxt   = cnt6_r;
    detect_nxt = detect_r;

    result.detect_updated   = 1'b0;
    result.modem_line_write = 1'b0;
    result.action           = ACT_NONE;
    result.resample_request = 1'b0;

    if (cfg.sensor_enabled) begin
      if (!item.mode) begin
        if (!wood_r) begin
          detect_nxt              = |(item.status & ST_BOTH);
          result.detect_updated   = 1'b1;
          result.modem_line_write = cfg.modem_line_enable;
          if (ovf) begin
            result.action = ACT_WOOD;
            wood_nxt      = 1'b1;
            snap_nxt      = item.status;
            cnt2_nxt      = '0;
            cnt6_nxt      = '0;
          end else begin
            // saturate at all ones
            if (mid2 && (cnt2_r != RAIL_HI)) cnt2_nxt = cnt2_r + 8'd1;
            if (mid6 && (cnt6_r != RAIL_HI)) cnt6_nxt = cnt6_r + 8'd1;
            if ((cnt2_nxt >= cfg.recal_limit) || (cnt6_nxt >= cfg.recal_limit)) begin
              result.action = ACT_RECAL;
              cnt2_nxt      = '0;
              cnt6_nxt      = '0;
            end
          end
        end
      end else if (wood_r && rel) begin
        result.action           = ACT_NORMAL;
        result.resample_request = 1'b1;
        wood_nxt                = 1'b0;
      end
    end

    result.object_detected = detect_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wood_r   <= 1'b0;
      snap_r   <= '0;
      cnt2_r   <= '0;
      cnt6_r   <= '0;
      detect_r <= 1'b0;
    end else if (advance) begin
      wood_r   <= wood_nxt;
      snap_r   <= snap_nxt;
      cnt2_r   <= cnt2_nxt;
      cnt6_r   <= cnt6_nxt;
      detect_r <= detect_nxt;
    end
  end

endmodule

@@ sv/sar_proximity_sensitivity_policy_top.sv @@
// Proximity sensitivity supervisor, top level.
// Data path: input register, policy logic, result register; the result is
// registered and transfers only once out_ready is high. Throughput: one item
// per cycle while out_ready stays high, set by the single-pass policy stage.
// Synchronous active-low reset clears both stage valid flags and the policy
// state, and returns the configuration registers to their reset values.
module sar_proximity_sensitivity_policy_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_status,
  input  logic [7:0] in_delta_ch2,
  input  logic [7:0] in_delta_ch6,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_object_detected,
  output logic       out_detect_updated,
  output logic       out_modem_line_write,
  output logic [1:0] out_action,
  output logic       out_resample_request
);
  import sps_pkg::*;

  sps_cfg_t    cfg;
  sps_item_t   item_r;
  logic        item_vld_r;
  sps_result_t res;
  sps_result_t res_r;
  logic        res_vld_r;
  logic        advance;

  assign cfg_ready = 1'b1;

  sps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // move the held item into the result register when that slot frees up
  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode      <= in_mode;
      item_r.status    <= in_status;
      item_r.delta_ch2 <= in_delta_ch2;
      item_r.delta_ch6 <= in_delta_ch6;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) item_vld_r <= in_valid;
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  sps_policy u_policy (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res)
  );

  assign out_valid            = res_vld_r;
  assign out_object_detected  = res_r.object_detected;
  assign out_detect_updated   = res_r.detect_updated;
  assign out_modem_line_write = res_r.modem_line_write;
  assign out_action           = res_r.action;
  assign out_resample_request = res_r.resample_request;

endmodule
